// ----- hdl/physical_page_allocator_macros.svh -----
// Assertion macros shared by the page allocator RTL.
`ifndef PHYSICAL_PAGE_ALLOCATOR_MACROS_SVH
`define PHYSICAL_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/ppa_pkg.sv -----
// Shared types, constants and helper functions of the page allocator.
package ppa_pkg;

    // Build capacity default
    localparam int PpaMaxPages = 256;

    // Used-map row organization
    localparam int RowW    = 16;
    localparam int RowSh   = $clog2(RowW);
    localparam int RowCntW = $clog2(RowW + 1);

    // Field and register widths
    localparam int CmdW     = 3;
    localparam int PageNumW = 9;
    localparam int StatusW  = 2;
    localparam int IdxOutW  = 8;
    localparam int OffW     = 20;
    localparam int CountW   = 9;
    localparam int SizeW    = 13;
    localparam int ProcW    = 8;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 13;

    // Random generator
    localparam int         LfsrW    = 16;
    localparam logic [15:0] LfsrTaps = 16'hB400;
    localparam logic [15:0] LfsrSeed = 16'hACE1;
    localparam logic [15:0] MaxDraws = 16'hFFFF;

    // Register reset values and limits
    localparam int               PageCountReset = 256;
    localparam logic [SizeW-1:0] PageSizeReset  = 13'd128;
    localparam logic [SizeW-1:0] PageSizeMax    = 13'd4096;
    localparam logic [ProcW-1:0] ProcReset      = 8'd1;
    localparam logic [ProcW-1:0] ProcMax        = 8'd255;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgPageCount = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgPageSize  = 1'b1;

    typedef enum logic [CmdW-1:0] {
        CmdAllocLow  = 3'd0,
        CmdAllocRand = 3'd1,
        CmdRelease   = 3'd2,
        CmdAddProc   = 3'd3,
        CmdDropProc  = 3'd4
    } t_cmd;

    typedef enum logic [StatusW-1:0] {
        StOk      = 2'd0,
        StNoFree  = 2'd1,
        StBadPage = 2'd2
    } t_status;

    // One Galois LFSR step
    function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] v);
        logic [LfsrW-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LfsrTaps;
        end
        return s;
    endfunction

    // Count set bits of a row, nibble sums first
    function automatic logic [RowCntW-1:0] row_popcount(input logic [RowW-1:0] v);
        logic [2:0]         nib [4];
        logic [RowCntW-1:0] sum;
        for (int n = 0; n < 4; n++) begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        sum = RowCntW'(nib[0]) + RowCntW'(nib[1]) + RowCntW'(nib[2]) + RowCntW'(nib[3]);
        return sum;
    endfunction

    // Position of the lowest set bit of a row
    function automatic logic [RowSh-1:0] row_first(input logic [RowW-1:0] v);
        logic [RowSh-1:0] pos;
        pos = '0;
        for (int k = RowW - 1; k >= 0; k--) begin
            if (v[k]) begin
                pos = RowSh'(k);
            end
        end
        return pos;
    endfunction

endpackage

// ----- hdl/ppa_map_ram.sv -----
// Used-map row memory: one write port, one registered read port, row valid bits.
module ppa_map_ram import ppa_pkg::*; #(
    parameter int ROWS = PpaMaxPages / RowW,
    parameter int AW   = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output logic [RowW-1:0] o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [RowW-1:0] i_wr_data
);

    logic [RowW-1:0] r_mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [RowW-1:0] r_rd_data;

    // Write the row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark written rows; reset frees every row at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Read with forwarding of a same-cycle write; unwritten rows read as free
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_row_vld[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/ppa_rand.sv -----
// Random page draw: LFSR step, then bit-serial remainder by the page count.
module ppa_rand import ppa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CountW-1:0] i_modulus,
    output logic              o_done,
    output logic [CountW-1:0] o_value
);

    localparam int CntW = $clog2(LfsrW);
    localparam logic [CntW-1:0] CntLast = CntW'(LfsrW - 1);

    logic [LfsrW-1:0]  r_lfsr;
    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [LfsrW-1:0]  r_div;
    logic [CountW-1:0] r_rem;
    logic [CountW-1:0] r_mod;
    logic [LfsrW-1:0]  w_lfsr_nxt;
    logic [CountW:0]   w_trial;
    logic [CountW:0]   w_mod_ext;
    logic [CountW-1:0] w_rem_nxt;

    assign w_lfsr_nxt = lfsr_next(r_lfsr);

    // Restoring remainder step: shift in one dividend bit, subtract if it fits
    assign w_trial   = {r_rem, r_div[LfsrW-1]};
    assign w_mod_ext = {1'b0, r_mod};
    assign w_rem_nxt = (w_trial >= w_mod_ext) ? CountW'(w_trial - w_mod_ext)
                                              : CountW'(w_trial);

    // Advance the generator on start, then iterate one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LfsrSeed;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_lfsr <= w_lfsr_nxt;
                r_div  <= w_lfsr_nxt;
                r_rem  <= '0;
                r_mod  <= i_modulus;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_rem_nxt;
                r_div <= r_div << 1;
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntLast) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_rem;

endmodule

// ----- hdl/physical_page_allocator.sv -----
// Top level of the bitmap page-frame allocator: command sequencer and result register.
//
// Bitmap page allocator. The used map lives in a row memory of 16 pages per row
// with a registered read, and every map update is a read-modify-write of one row.
// One request is handled at a time: process commands, failed allocations and
// invalid releases go straight to the offset multiply, a valid release first
// checks and clears its page bit, a lowest-free allocation scans at most every
// managed row from row zero, and a random allocation runs draws through the
// 16-step serial remainder unit until a free page is hit or MaxDraws draws are
// spent, then scans. Writing page_count while idle or recounting starts a recount
// of free pages, one row per cycle, during which no request is taken. A finished
// result waits in the output register while the next request is accepted.
`include "physical_page_allocator_macros.svh"

module physical_page_allocator import ppa_pkg::*; #(
    parameter int MAX_PAGES = PpaMaxPages
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CmdW-1:0]     i_command,
    input  logic signed [PageNumW-1:0] i_page_number,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [StatusW-1:0]  o_status,
    output logic [IdxOutW-1:0]  o_page_index,
    output logic [OffW-1:0]     o_page_offset,
    output logic [CountW-1:0]   o_free_count,
    output logic [ProcW-1:0]    o_process_count,
    output logic                o_any_process
);

    localparam int Rows  = (MAX_PAGES + RowW - 1) / RowW;
    localparam int RowAw = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int PW    = RowAw + RowSh;
    localparam int ProdW = PW + SizeW;
    localparam logic [CountW-1:0] EffReset =
        (MAX_PAGES < PageCountReset) ? CountW'(MAX_PAGES) : CountW'(PageCountReset);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_DRAW     = 8'b0000_0100,
        S_RAND_CHK = 8'b0000_1000,
        S_REL_CHK  = 8'b0001_0000,
        S_RECOUNT  = 8'b0010_0000,
        S_MUL      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state            r_state;
    logic [CountW-1:0] r_eff_n;
    logic [SizeW-1:0]  r_eff_size;
    logic [CountW-1:0] r_free;
    logic [ProcW-1:0]  r_procs;
    logic [RowAw-1:0]  r_row;
    logic [CountW-1:0] r_acc;
    logic [15:0]       r_tries;
    logic [PW-1:0]     r_page;
    t_status           r_status;
    logic [ProdW-1:0]  r_prod;
    logic              r_out_vld;
    logic [StatusW-1:0] r_out_status;
    logic [IdxOutW-1:0] r_out_index;
    logic [OffW-1:0]    r_out_offset;
    logic [CountW-1:0]  r_out_free;
    logic [ProcW-1:0]   r_out_procs;
    logic               r_out_any;

    logic              w_in_xfer;
    logic              w_out_load;
    logic [CountW-1:0] w_cfg_cnt;
    logic [CountW-1:0] w_cfg_n;
    logic [SizeW-1:0]  w_cfg_size;
    logic              w_cnt_wr;
    logic [PageNumW-1:0] w_raw;
    logic              w_rel_bad;
    logic [PW-1:0]     w_raw_page;
    logic [CountW-1:0] w_n_m1;
    logic [RowAw-1:0]  w_last_row;
    logic              w_last;
    logic [RowW-1:0]   w_row_mask;
    logic [RowW-1:0]   w_row_free;
    logic              w_any;
    logic [RowSh-1:0]  w_ffz;
    logic [CountW-1:0] w_acc_nxt;
    logic              w_bit_used;
    logic              w_rand_start;
    logic              w_rand_done;
    logic [CountW-1:0] w_rand_val;
    logic [PW-1:0]     w_rand_page;
    logic              w_rd_en;
    logic [RowAw-1:0]  w_rd_addr;
    logic [RowW-1:0]   w_rd_data;
    logic              w_wr_en;
    logic [RowAw-1:0]  w_wr_addr;
    logic [RowW-1:0]   w_wr_data;

    // Handshakes
    assign o_ready    = (r_state == S_IDLE) && !i_cfg_we;
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_vld || i_ready);

    // Clamp configuration values
    assign w_cfg_cnt  = i_cfg_wdata[CountW-1:0];
    assign w_cfg_n    = (w_cfg_cnt == '0) ? CountW'(1) :
                        ((32'(w_cfg_cnt) > 32'(MAX_PAGES)) ? CountW'(MAX_PAGES) : w_cfg_cnt);
    assign w_cfg_size = (i_cfg_wdata[SizeW-1:0] > PageSizeMax) ? PageSizeMax
                                                                : i_cfg_wdata[SizeW-1:0];
    assign w_cnt_wr   = i_cfg_we && (i_cfg_idx == CfgPageCount);

    // Release page check; negative numbers carry the top bit
    assign w_raw      = i_page_number;
    assign w_rel_bad  = w_raw[PageNumW-1] || (w_raw >= r_eff_n);
    assign w_raw_page = PW'(w_raw);

    // Row bookkeeping: last managed row and the managed bits of the current row
    assign w_n_m1     = r_eff_n - CountW'(1);
    assign w_last_row = RowAw'(w_n_m1 >> RowSh);
    assign w_last     = (r_row == w_last_row);

    always_comb begin
        for (int k = 0; k < RowW; k++) begin
            w_row_mask[k] = (r_row != w_last_row) || (RowSh'(k) <= w_n_m1[RowSh-1:0]);
        end
    end

    assign w_row_free  = ~w_rd_data & w_row_mask;
    assign w_any       = |w_row_free;
    assign w_ffz       = row_first(w_row_free);
    assign w_acc_nxt   = r_acc + CountW'(row_popcount(w_row_free));
    assign w_bit_used  = w_rd_data[r_page[RowSh-1:0]];
    assign w_rand_page = PW'(w_rand_val);

    // Memory port and draw control
    always_comb begin
        w_rd_en      = 1'b0;
        w_rd_addr    = r_row;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_page[PW-1:RowSh];
        w_wr_data    = w_rd_data;
        w_rand_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if ((t_cmd'(i_command) == CmdRelease) && !w_rel_bad) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_raw_page[PW-1:RowSh];
                    end else if ((t_cmd'(i_command) == CmdAllocLow) && (r_free != '0)) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                    end else if ((t_cmd'(i_command) == CmdAllocRand) && (r_free != '0)) begin
                        w_rand_start = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_any) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_row;
                    w_wr_data = w_rd_data | (RowW'(1) << w_ffz);
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_last ? '0 : r_row + RowAw'(1);
                end
            end
            S_DRAW: begin
                if (w_rand_done) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rand_page[PW-1:RowSh];
                end
            end
            S_RAND_CHK: begin
                if (!w_bit_used) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_rd_data | (RowW'(1) << r_page[RowSh-1:0]);
                end else if (r_tries == (MaxDraws - 16'd1)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = '0;
                end else begin
                    w_rand_start = 1'b1;
                end
            end
            S_REL_CHK: begin
                if (w_bit_used) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_rd_data & ~(RowW'(1) << r_page[RowSh-1:0]);
                end
            end
            S_RECOUNT: begin
                if (!w_last) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_row + RowAw'(1);
                end
            end
            default: begin
            end
        endcase
        // A page count write while idle or recounting starts the recount at row zero
        if (w_cnt_wr && ((r_state == S_IDLE) || (r_state == S_RECOUNT))) begin
            w_rd_en   = 1'b1;
            w_rd_addr = '0;
        end
    end

    ppa_map_ram #(
        .ROWS (Rows),
        .AW   (RowAw)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    ppa_rand u_rand (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rand_start),
        .i_modulus (r_eff_n),
        .o_done    (w_rand_done),
        .o_value   (w_rand_val)
    );

    // Sequencer and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_eff_n    <= EffReset;
            r_eff_size <= PageSizeReset;
            r_free     <= EffReset;
            r_procs    <= ProcReset;
            r_out_vld  <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_we && (i_cfg_idx == CfgPageCount)) begin
                r_eff_n <= w_cfg_n;
            end
            if (i_cfg_we && (i_cfg_idx == CfgPageSize)) begin
                r_eff_size <= w_cfg_size;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_status <= StOk;
                        r_page   <= '0;
                        r_state  <= S_MUL;
                        unique case (t_cmd'(i_command))
                            CmdAllocLow: begin
                                if (r_free == '0) begin
                                    r_status <= StNoFree;
                                end else begin
                                    r_row   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            CmdAllocRand: begin
                                if (r_free == '0) begin
                                    r_status <= StNoFree;
                                end else begin
                                    r_tries <= '0;
                                    r_state <= S_DRAW;
                                end
                            end
                            CmdRelease: begin
                                if (w_rel_bad) begin
                                    r_status <= StBadPage;
                                end else begin
                                    r_page  <= w_raw_page;
                                    r_state <= S_REL_CHK;
                                end
                            end
                            CmdAddProc: begin
                                if (r_procs != ProcMax) begin
                                    r_procs <= r_procs + ProcW'(1);
                                end
                            end
                            CmdDropProc: begin
                                if (r_procs != '0) begin
                                    r_procs <= r_procs - ProcW'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_any) begin
                        r_page  <= {r_row, w_ffz};
                        r_free  <= r_free - CountW'(1);
                        r_state <= S_MUL;
                    end else begin
                        r_row <= w_last ? '0 : r_row + RowAw'(1);
                    end
                end
                S_DRAW: begin
                    if (w_rand_done) begin
                        r_page  <= w_rand_page;
                        r_state <= S_RAND_CHK;
                    end
                end
                S_RAND_CHK: begin
                    if (!w_bit_used) begin
                        r_free  <= r_free - CountW'(1);
                        r_state <= S_MUL;
                    end else if (r_tries == (MaxDraws - 16'd1)) begin
                        // Draw budget spent: take the lowest free page
                        r_row   <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_tries <= r_tries + 16'd1;
                        r_state <= S_DRAW;
                    end
                end
                S_REL_CHK: begin
                    if (w_bit_used) begin
                        r_free <= r_free + CountW'(1);
                    end
                    r_state <= S_MUL;
                end
                S_RECOUNT: begin
                    if (w_last) begin
                        r_free  <= w_acc_nxt;
                        r_state <= S_IDLE;
                    end else begin
                        r_acc <= w_acc_nxt;
                        r_row <= r_row + RowAw'(1);
                    end
                end
                S_MUL: begin
                    r_prod  <= ProdW'(r_page) * ProdW'(r_eff_size);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Restart the free-page recount on a page count write while idle or recounting
            if (w_cnt_wr && ((r_state == S_IDLE) || (r_state == S_RECOUNT))) begin
                r_row   <= '0;
                r_acc   <= '0;
                r_state <= S_RECOUNT;
            end

            // Hold the result until its transfer
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_index  <= IdxOutW'(r_page);
            r_out_offset <= OffW'(r_prod);
            r_out_free   <= r_free;
            r_out_procs  <= r_procs;
            r_out_any    <= (r_procs != '0);
        end
    end

    assign o_valid         = r_out_vld;
    assign o_status        = r_out_status;
    assign o_page_index    = r_out_index;
    assign o_page_offset   = r_out_offset;
    assign o_free_count    = r_out_free;
    assign o_process_count = r_out_procs;
    assign o_any_process   = r_out_any;

    // Checks
    `PPA_ASSERT_IMP(a_free_in_range, i_clk, i_rst_n, r_state != S_RECOUNT, r_free <= r_eff_n, "free count above managed pages")
    `PPA_ASSERT_IMP(a_draw_owned, i_clk, i_rst_n, w_rand_done, r_state == S_DRAW, "draw finished outside draw state")
    `PPA_ASSERT_IMP(a_no_rmw_overlap, i_clk, i_rst_n, w_wr_en, !w_rd_en, "map read and write in one cycle")
    `PPA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status != StOk), (o_page_index == '0) && (o_page_offset == '0), "failed result carries a page")
    `PPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_in_xfer, r_state != S_IDLE, "request accepted but sequencer idle")

endmodule

// ----- test/physical_page_allocator_checker.sv -----
// Checker for the page allocator: tracks the allocator state and compares every result.
`timescale 1ns / 100ps

module physical_page_allocator_checker import ppa_pkg::*; #(
    parameter int MAX_PAGES = PpaMaxPages
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic [CmdW-1:0]     i_command,
    input  logic [PageNumW-1:0] i_page_number,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  logic [StatusW-1:0]  i_status,
    input  logic [IdxOutW-1:0]  i_page_index,
    input  logic [OffW-1:0]     i_page_offset,
    input  logic [CountW-1:0]   i_free_count,
    input  logic [ProcW-1:0]    i_process_count,
    input  logic                i_any_process,
    output int                  o_pending,
    output int                  o_fail_count
);

    typedef struct packed {
        t_status             status;
        logic [IdxOutW-1:0]  page_index;
        logic [OffW-1:0]     page_offset;
        logic [CountW-1:0]   free_count;
        logic [ProcW-1:0]    process_count;
        logic                any_process;
    } alloc_result_t;

    // Shadow of the allocator state and its registers
    logic [MAX_PAGES-1:0] used_map;
    int                   free_pages;
    logic [LfsrW-1:0]     rand_state;
    logic [ProcW-1:0]     procs;
    logic [CountW-1:0]    cfg_page_count;
    logic [SizeW-1:0]     cfg_page_size;

    // Results owed by the allocator, oldest first
    alloc_result_t due_results[$];

    // Clamp the page count register to the managed range
    function automatic int managed_pages();
        if (cfg_page_count == 0) begin
            return 1;
        end
        if (int'(cfg_page_count) > MAX_PAGES) begin
            return MAX_PAGES;
        end
        return int'(cfg_page_count);
    endfunction

    function automatic int bytes_per_page();
        return (cfg_page_size > PageSizeMax) ? int'(PageSizeMax) : int'(cfg_page_size);
    endfunction

    function automatic int lowest_free(input int n);
        for (int p = 0; p < n; p++) begin
            if (!used_map[p]) begin
                return p;
            end
        end
        return 0;
    endfunction

    function automatic void count_free_pages();
        int n;
        n = managed_pages();
        free_pages = 0;
        for (int p = 0; p < n; p++) begin
            if (!used_map[p]) begin
                free_pages++;
            end
        end
    endfunction

    // Shift right, fold the taps back in when a one drops out
    function automatic logic [LfsrW-1:0] advance_lfsr(input logic [LfsrW-1:0] s);
        return {1'b0, s[LfsrW-1:1]} ^ (s[0] ? LfsrTaps : '0);
    endfunction

    // Apply one request to the shadow state and form its result
    function automatic alloc_result_t serve_request(input logic [CmdW-1:0] cmd,
                                                    input logic [PageNumW-1:0] pnum);
        alloc_result_t r;
        int            n;
        int            page;
        int            draws;
        logic          found;
        logic          touched;
        n       = managed_pages();
        r       = '0;
        page    = 0;
        found   = 1'b0;
        touched = 1'b0;
        case (cmd)
            CmdAllocLow, CmdAllocRand: begin
                if (free_pages == 0) begin
                    r.status = StNoFree;
                end else begin
                    if (cmd == CmdAllocRand) begin
                        // redraw until a free page turns up, bounded by the draw limit
                        for (draws = 0; draws < int'(MaxDraws) && !found; draws++) begin
                            rand_state = advance_lfsr(rand_state);
                            page       = int'(rand_state) % n;
                            found      = !used_map[page];
                        end
                    end
                    if (!found) begin
                        page = lowest_free(n);
                    end
                    used_map[page] = 1'b1;
                    free_pages--;
                    touched = 1'b1;
                end
            end
            CmdRelease: begin
                if (pnum[PageNumW-1] || int'(pnum) >= n) begin
                    r.status = StBadPage;
                end else begin
                    page = int'(pnum);
                    if (used_map[page]) begin
                        used_map[page] = 1'b0;
                        free_pages++;
                    end
                    touched = 1'b1;
                end
            end
            CmdAddProc: begin
                if (procs != ProcMax) begin
                    procs++;
                end
            end
            CmdDropProc: begin
                if (procs != '0) begin
                    procs--;
                end
            end
            default: begin
            end
        endcase
        if (touched) begin
            r.page_index  = IdxOutW'(page);
            r.page_offset = OffW'(page * bytes_per_page());
        end
        r.free_count    = CountW'(free_pages);
        r.process_count = procs;
        r.any_process   = (procs != '0);
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, seen);
            o_fail_count++;
        end
    endfunction

    // Follow register writes and transfers on both channels
    always @(posedge i_clk) begin : track
        alloc_result_t want;
        if (!i_rst_n) begin
            used_map       = '0;
            rand_state     = LfsrSeed;
            procs          = ProcReset;
            cfg_page_count = CountW'(PageCountReset);
            cfg_page_size  = PageSizeReset;
            count_free_pages();
            due_results.delete();
            o_fail_count   = 0;
            o_pending     <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgPageCount) begin
                    cfg_page_count = i_cfg_wdata[CountW-1:0];
                    count_free_pages();
                end else begin
                    cfg_page_size = i_cfg_wdata[SizeW-1:0];
                end
            end
            if (i_req_valid && i_req_ready) begin
                due_results.push_back(serve_request(i_command, i_page_number));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d, page %0d",
                           i_status, i_page_index);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("page_index", want.page_index, i_page_index);
                    check_field("page_offset", want.page_offset, i_page_offset);
                    check_field("free_count", want.free_count, i_free_count);
                    check_field("process_count", want.process_count, i_process_count);
                    check_field("any_process", want.any_process, i_any_process);
                end
            end
            o_pending <= due_results.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
// Stimulus and verdict for the page allocator, with the checker beside the allocator.
`timescale 1ns / 100ps

module testbench import ppa_pkg::*;;

    localparam int HalfPeriod = 5;
    localparam int ResetCycles = 7;
    localparam int PhaseCount = 24;
    localparam int ProcRamp = 260;
    localparam int SettleCycles = 64;
    // A random allocation may need up to 65535 draws before its fallback scan
    localparam int QuietLimit = 4_000_000;

    typedef enum int {
        IdleNone,
        IdleSparse,
        IdleBusy
    } idle_mode_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [CmdW-1:0]     i_command = '0;
    logic [PageNumW-1:0] i_page_number = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [StatusW-1:0]  o_status;
    logic [IdxOutW-1:0]  o_page_index;
    logic [OffW-1:0]     o_page_offset;
    logic [CountW-1:0]   o_free_count;
    logic [ProcW-1:0]    o_process_count;
    logic                o_any_process;

    int         pending;
    int         fail_count;
    int         quiet_cycles = 0;
    idle_mode_t src_mode = IdleNone;
    idle_mode_t sink_mode = IdleNone;

    always #HalfPeriod i_clk = ~i_clk;

    physical_page_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_page_index    (o_page_index),
        .o_page_offset   (o_page_offset),
        .o_free_count    (o_free_count),
        .o_process_count (o_process_count),
        .o_any_process   (o_any_process)
    );

    physical_page_allocator_checker alloc_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_command       (i_command),
        .i_page_number   (i_page_number),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_status        (o_status),
        .i_page_index    (o_page_index),
        .i_page_offset   (o_page_offset),
        .i_free_count    (o_free_count),
        .i_process_count (o_process_count),
        .i_any_process   (o_any_process),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    function automatic int draw_gap(input idle_mode_t mode);
        case (mode)
            IdleNone:   return 0;
            IdleSparse: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
            default:    return int'($urandom_range(0, 17));
        endcase
    endfunction

    // Allocation-heavy mix fills small maps; roomy maps lean on release
    function automatic logic [CmdW-1:0] pick_command(input bit roomy);
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roomy) begin
            if (roll < 12) return CmdAllocLow;
            if (roll < 25) return CmdAllocRand;
        end else begin
            if (roll < 20) return CmdAllocLow;
            if (roll < 42) return CmdAllocRand;
        end
        if (roll < 75) return CmdRelease;
        if (roll < 85) return CmdAddProc;
        if (roll < 95) return CmdDropProc;
        return CmdW'($urandom_range(int'(CmdDropProc) + 1, (1 << CmdW) - 1));
    endfunction

    // Mostly managed pages, some no-page markers and raw values
    function automatic logic [PageNumW-1:0] pick_page(input int span);
        int roll;
        roll = int'($urandom_range(0, 19));
        if (roll < 15) return PageNumW'($urandom_range(0, span - 1));
        if (roll < 17) return '1;
        return PageNumW'($urandom_range(0, (1 << PageNumW) - 1));
    endfunction

    // Hold the request until the allocator takes it; valid stays up afterwards
    task automatic send_request(input logic [CmdW-1:0] cmd, input logic [PageNumW-1:0] pnum);
        int gap;
        gap = draw_gap(src_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_page_number <= pnum;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    // Drop valid and wait for every owed result
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Size first, then count, so the recount runs last
    task automatic set_geometry(input logic [CfgDataW-1:0] count_word,
                                input logic [CfgDataW-1:0] size_word);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CfgPageSize;
        i_cfg_wdata <= size_word;
        @(posedge i_clk);
        i_cfg_idx   <= CfgPageCount;
        i_cfg_wdata <= count_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stall the result channel a random number of cycles per transfer
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_gap(sink_mode);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                  items;
        int                  span;
        int                  sel;
        logic [CfgDataW-1:0] count_word;
        logic [CfgDataW-1:0] size_word;

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default geometry: both allocations, releases of free, used and bad pages
        src_mode  = IdleSparse;
        sink_mode = IdleSparse;
        send_request(CmdAllocLow, '0);
        send_request(CmdAllocRand, '0);
        send_request(CmdRelease, '0);
        send_request(CmdRelease, '0);
        send_request(CmdRelease, '1);
        send_request(CmdRelease, {1'b1, {(PageNumW - 1){1'b0}}});
        send_request(CmdRelease, PageNumW'(PpaMaxPages - 1));
        // Process count down through zero, then back up
        send_request(CmdDropProc, '0);
        send_request(CmdDropProc, '0);
        send_request(CmdAddProc, '0);
        for (int code = int'(CmdDropProc) + 1; code < (1 << CmdW); code++) begin
            send_request(CmdW'(code), '1);
        end

        // Two pages at the largest size: fill, fail both ways, bad and good release
        wait_drained();
        set_geometry(CfgDataW'(2), PageSizeMax);
        send_request(CmdAllocLow, '0);
        send_request(CmdAllocRand, '0);
        send_request(CmdAllocLow, '0);
        send_request(CmdAllocRand, '0);
        send_request(CmdRelease, PageNumW'(2));
        send_request(CmdRelease, PageNumW'(1));

        // Zero count acts as one page, oversize page clamps to the maximum
        wait_drained();
        set_geometry('0, '1);
        send_request(CmdAllocRand, '0);
        send_request(CmdRelease, '0);
        send_request(CmdAllocRand, '0);

        // Over-range count acts as full capacity, zero size gives zero offsets
        wait_drained();
        set_geometry(CfgDataW'(PpaMaxPages + 44), '0);
        send_request(CmdAllocLow, '0);
        send_request(CmdRelease, PageNumW'(PpaMaxPages - 1));

        // Push the process count into its upper limit
        wait_drained();
        src_mode  = IdleNone;
        sink_mode = IdleSparse;
        repeat (ProcRamp) send_request(CmdAddProc, pick_page(PpaMaxPages));

        // Random phases, each on a fresh geometry and idle pattern
        for (int phase = 0; phase < PhaseCount; phase++) begin
            wait_drained();
            sel = int'($urandom_range(0, 9));
            if (sel < 6) begin
                count_word = CfgDataW'($urandom_range(1, 16));
            end else if (sel == 6) begin
                count_word = CfgDataW'($urandom_range(17, PpaMaxPages));
            end else if (sel == 7) begin
                count_word = CfgDataW'(PpaMaxPages);
            end else if (sel == 8) begin
                count_word = CfgDataW'($urandom_range(PpaMaxPages + 1, (1 << CfgDataW) - 1));
            end else begin
                count_word = '0;
            end
            case ($urandom_range(0, 5))
                0:       size_word = '0;
                1:       size_word = CfgDataW'(1);
                2:       size_word = PageSizeMax;
                3:       size_word = CfgDataW'($urandom_range(int'(PageSizeMax) + 1,
                                                              (1 << CfgDataW) - 1));
                default: size_word = CfgDataW'($urandom_range(0, (1 << CfgDataW) - 1));
            endcase
            set_geometry(count_word, size_word);

            // Pages the register value covers once masked and clamped
            span = int'(count_word[CountW-1:0]);
            if (span == 0) begin
                span = 1;
            end else if (span > PpaMaxPages) begin
                span = PpaMaxPages;
            end

            src_mode  = idle_mode_t'($urandom_range(0, 2));
            sink_mode = idle_mode_t'($urandom_range(0, 2));
            items     = int'($urandom_range(50, 80));
            repeat (items) send_request(pick_command(span > 32), pick_page(span));
        end

        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ppa_pkg.sv
hdl/ppa_map_ram.sv
hdl/ppa_rand.sv
hdl/physical_page_allocator.sv
test/physical_page_allocator_checker.sv
test/testbench.sv
